### hdl/bli_pkg.sv
// Shared constants for the bracket language interpreter.
package bli_pkg;

  localparam int ProgDepthDef = 4096;
  localparam int TapeDepthDef = 32768;

  localparam int REQ_W  = 2;
  localparam int ADDR_W = 13;
  localparam int BYTE_W = 8;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;  // >
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;  // <
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;  // +
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;  // -
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;  // .
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;  // ]

endpackage

### hdl/bli_if.sv
// Request and response channel interfaces of the interpreter.
interface bli_req_if;
  logic                        valid;
  logic                        ready;
  logic [bli_pkg::REQ_W-1:0]   req_type;
  logic [bli_pkg::ADDR_W-1:0]  prog_addr;
  logic [bli_pkg::BYTE_W-1:0]  prog_byte;

  modport source (output valid, req_type, prog_addr, prog_byte, input ready);
  modport sink   (input valid, req_type, prog_addr, prog_byte, output ready);
endinterface

interface bli_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        out_valid;
  logic [bli_pkg::BYTE_W-1:0]  out_char;
  logic                        halted;

  modport source (output valid, out_valid, out_char, halted, input ready);
  modport sink   (input valid, out_valid, out_char, halted, output ready);
endinterface

### hdl/bli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/bracket_language_interpreter.sv
// Bracket tape language interpreter: program store and tape in synchronous RAMs.
// Load, start, unknown, halted step: result registered at the accept edge, one item per cycle,
// while the output register is free, else parked in RESP. Simple step: EXEC decodes and
// writes back, then the result is registered. Taken bracket: EXEC, then FWD or BWD scans
// the program bytes to the match or to the program's edge. Reset: control clears at once,
// then a clearing pass zeroes every tape cell, during which no item is accepted.
module bracket_language_interpreter #(
  parameter int PROG_DEPTH = bli_pkg::ProgDepthDef,
  parameter int TAPE_DEPTH = bli_pkg::TapeDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bli_req_if.sink   req_i,
  bli_rsp_if.source rsp_o
);

  // Program index, program counter / length (can hold PROG_DEPTH), tape index.
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int LW  = $clog2(PROG_DEPTH + 1);
  localparam int TAW = $clog2(TAPE_DEPTH);
  // Common width for comparing the 13-bit address field against the store depth.
  localparam int XW  = (LW > bli_pkg::ADDR_W) ? LW : bli_pkg::ADDR_W;
  localparam logic [TAW-1:0] TAPE_LAST = TAW'(TAPE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,  // zero the tape after reset
    S_IDLE,   // wait for an item, reads of pc and head are in flight
    S_EXEC,   // decode the instruction, write back the cell
    S_FWD,    // scan forward for the matching close bracket
    S_BWD,    // scan backward for the matching open bracket
    S_RESP    // hold a finished result until the output register frees
  } state_e;

  state_e                    state_q, state_d;
  logic [TAW-1:0]            clr_q, clr_d;
  logic [TAW-1:0]            head_q, head_d;
  logic [LW-1:0]             pc_q, pc_d;
  logic [LW-1:0]             len_q, len_d;
  logic [LW-1:0]             scan_q, scan_d;
  logic [LW-1:0]             depth_q, depth_d;
  logic                      pend_q, pend_d;
  logic                      r_outv_q, r_outv_d;
  logic [bli_pkg::BYTE_W-1:0] r_char_q, r_char_d;
  logic                      ov_q, ov_d;
  logic                      o_outv_q, o_outv_d;
  logic [bli_pkg::BYTE_W-1:0] o_char_q, o_char_d;
  logic                      o_halt_q, o_halt_d;

  // Memory ports.
  logic                       prog_we;
  logic [PAW-1:0]             prog_waddr;
  logic [LW-1:0]              prog_raddr;
  logic [bli_pkg::BYTE_W-1:0] prog_rdata;
  logic                       tape_we;
  logic [TAW-1:0]             tape_waddr;
  logic [bli_pkg::BYTE_W-1:0] tape_wdata;
  logic [bli_pkg::BYTE_W-1:0] tape_rdata;

  // Finish handshake between the instruction logic and the output register.
  logic                       fin;
  logic                       fin_outv;
  logic [bli_pkg::BYTE_W-1:0] fin_char;
  logic                       out_free;
  logic                       match;
  logic [XW-1:0]              addr_x;
  logic [LW-1:0]              scan_inc;
  logic [LW-1:0]              scan_dec;

  assign addr_x     = XW'(req_i.prog_addr);
  assign prog_waddr = addr_x[PAW-1:0];
  assign scan_inc   = scan_q + LW'(1);
  assign scan_dec   = scan_q - LW'(1);
  assign out_free   = !ov_q || rsp_o.ready;

  // Items are taken only in IDLE; the output register decouples the response side.
  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = ov_q;
  assign rsp_o.out_valid = o_outv_q;
  assign rsp_o.out_char  = o_char_q;
  assign rsp_o.halted    = o_halt_q;

  bli_ram #(
    .WIDTH(bli_pkg::BYTE_W),
    .DEPTH(PROG_DEPTH)
  ) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(req_i.prog_byte),
    .raddr_i(prog_raddr[PAW-1:0]),
    .rdata_o(prog_rdata)
  );

  // The tape read always targets the head; a write-back at the end of EXEC lands
  // before the next IDLE read, so no forwarding is needed.
  bli_ram #(
    .WIDTH(bli_pkg::BYTE_W),
    .DEPTH(TAPE_DEPTH)
  ) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(head_q),
    .rdata_o(tape_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    head_d     = head_q;
    pc_d       = pc_q;
    len_d      = len_q;
    scan_d     = scan_q;
    depth_d    = depth_q;
    pend_d     = pend_q;
    r_outv_d   = r_outv_q;
    r_char_d   = r_char_q;
    ov_d       = ov_q;
    o_outv_d   = o_outv_q;
    o_char_d   = o_char_q;
    o_halt_d   = o_halt_q;
    prog_we    = 1'b0;
    prog_raddr = pc_q;
    tape_we    = 1'b0;
    tape_waddr = head_q;
    tape_wdata = '0;
    fin        = 1'b0;
    fin_outv   = 1'b0;
    fin_char   = '0;
    match      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        clr_d      = clr_q + TAW'(1);
        if (clr_q == TAPE_LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            bli_pkg::REQ_LOAD: begin
              prog_we = (addr_x < XW'(PROG_DEPTH));
              fin     = 1'b1;
            end
            bli_pkg::REQ_START: begin
              // Saturate the length at the store depth.
              len_d = (addr_x > XW'(PROG_DEPTH)) ? LW'(PROG_DEPTH) : addr_x[LW-1:0];
              pc_d  = '0;
              fin   = 1'b1;
            end
            bli_pkg::REQ_STEP: begin
              if (pc_q < len_q) begin
                state_d = S_EXEC;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_EXEC: begin
        pc_d = pc_q + LW'(1);
        case (prog_rdata)
          bli_pkg::CH_RIGHT: begin
            head_d = (head_q == TAPE_LAST) ? '0 : head_q + TAW'(1);
            fin    = 1'b1;
          end
          bli_pkg::CH_LEFT: begin
            head_d = (head_q == '0) ? TAPE_LAST : head_q - TAW'(1);
            fin    = 1'b1;
          end
          bli_pkg::CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
            fin        = 1'b1;
          end
          bli_pkg::CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
            fin        = 1'b1;
          end
          bli_pkg::CH_OUT: begin
            fin_outv = 1'b1;
            fin_char = tape_rdata;
            fin      = 1'b1;
          end
          bli_pkg::CH_OPEN: begin
            if (tape_rdata == '0) begin
              pc_d    = pc_q;
              scan_d  = pc_q;
              depth_d = LW'(1);
              pend_d  = 1'b0;
              state_d = S_FWD;
            end else begin
              fin = 1'b1;
            end
          end
          bli_pkg::CH_CLOSE: begin
            if (tape_rdata != '0) begin
              pc_d    = pc_q;
              scan_d  = pc_q;
              depth_d = LW'(1);
              pend_d  = 1'b0;
              state_d = S_BWD;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      // Streamed scan: check the byte read last cycle at scan_q while the read of
      // the next position is issued.
      S_FWD: begin
        if (pend_q) begin
          if (prog_rdata == bli_pkg::CH_CLOSE) begin
            if (depth_q == LW'(1)) begin
              match = 1'b1;
            end else begin
              depth_d = depth_q - LW'(1);
            end
          end else if (prog_rdata == bli_pkg::CH_OPEN) begin
            depth_d = depth_q + LW'(1);
          end
        end
        if (match) begin
          pc_d = scan_inc;
          fin  = 1'b1;
        end else if (scan_inc < len_q) begin
          prog_raddr = scan_inc;
          scan_d     = scan_inc;
          pend_d     = 1'b1;
        end else begin
          // Unmatched: halt the run.
          pc_d = len_q;
          fin  = 1'b1;
        end
      end

      S_BWD: begin
        if (pend_q) begin
          if (prog_rdata == bli_pkg::CH_OPEN) begin
            if (depth_q == LW'(1)) begin
              match = 1'b1;
            end else begin
              depth_d = depth_q - LW'(1);
            end
          end else if (prog_rdata == bli_pkg::CH_CLOSE) begin
            depth_d = depth_q + LW'(1);
          end
        end
        if (match) begin
          pc_d = scan_inc;
          fin  = 1'b1;
        end else if (scan_q != '0) begin
          prog_raddr = scan_dec;
          scan_d     = scan_dec;
          pend_d     = 1'b1;
        end else begin
          pc_d = len_q;
          fin  = 1'b1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_outv_d = r_outv_q;
          o_char_d = r_char_q;
          o_halt_d = (pc_q >= len_q);
          state_d  = S_IDLE;
        end else if (rsp_o.ready) begin
          ov_d = 1'b0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Drain the output register when taken, then load a finished result or park it.
    if (state_q != S_RESP) begin
      if (rsp_o.ready) begin
        ov_d = 1'b0;
      end
      if (fin) begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_outv_d = fin_outv;
          o_char_d = fin_char;
          o_halt_d = (pc_d >= len_d);
          state_d  = S_IDLE;
        end else begin
          r_outv_d = fin_outv;
          r_char_d = fin_char;
          state_d  = S_RESP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      head_q   <= '0;
      pc_q     <= '0;
      len_q    <= '0;
      scan_q   <= '0;
      depth_q  <= '0;
      pend_q   <= 1'b0;
      r_outv_q <= 1'b0;
      r_char_q <= '0;
      ov_q     <= 1'b0;
      o_outv_q <= 1'b0;
      o_char_q <= '0;
      o_halt_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      pc_q     <= pc_d;
      len_q    <= len_d;
      scan_q   <= scan_d;
      depth_q  <= depth_d;
      pend_q   <= pend_d;
      r_outv_q <= r_outv_d;
      r_char_q <= r_char_d;
      ov_q     <= ov_d;
      o_outv_q <= o_outv_d;
      o_char_q <= o_char_d;
      o_halt_q <= o_halt_d;
    end
  end

endmodule
